### rtl/latency_bucket_histogram_core_assert.svh
// assertion macros for the latency histogram core
// expects clk and arst_n in the scope that uses them
`ifndef LATENCY_BUCKET_HISTOGRAM_CORE_ASSERT_SVH
`define LATENCY_BUCKET_HISTOGRAM_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define LBH_ASSERT_NOW(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lbh check failed");

// next-cycle implication, checked out of reset
`define LBH_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lbh check failed");

`endif

### rtl/lbh_pkg.sv
// shared types and constants for the latency histogram core
// no dependencies
package lbh_pkg;

	localparam int KIND_W      = 2;
	localparam int SAMPLE_W    = 32;
	localparam int BOUND_W     = 32;
	localparam int NUM_BOUNDS  = 7;
	localparam int CFG_IDX_W   = 3;
	localparam int BUCKET_W    = 3;
	localparam int COUNT_W     = 48;
	localparam int SUM_W       = 64;
	localparam int NUM_BUCKETS_DEF = 8;

	localparam logic [BOUND_W-1:0] BOUND_RESET [NUM_BOUNDS] = '{
		32'd1000, 32'd5000, 32'd10000, 32'd25000, 32'd50000, 32'd100000, 32'd500000
	};

	typedef enum logic [KIND_W-1:0] {
		KIND_OBSERVE  = 2'd0,
		KIND_SNAPSHOT = 2'd1,
		KIND_CLEAR    = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_UPDATE,
		S_SNAP
	} state_t;

endpackage

### rtl/lbh_in_if.sv
// input channel of the latency histogram core: command kind and sample
// depends on lbh_pkg
interface lbh_in_if import lbh_pkg::*;;
	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   kind;
	logic [SAMPLE_W-1:0] sample;

	modport source (output valid, kind, sample, input ready);
	modport sink (input valid, kind, sample, output ready);
endinterface

### rtl/lbh_out_if.sv
// result channel of the latency histogram core: one beat per bucket
// depends on lbh_pkg
interface lbh_out_if import lbh_pkg::*;;
	logic                valid;
	logic                ready;
	logic [BUCKET_W-1:0] bucket_index;
	logic                overflow_bucket;
	logic [COUNT_W-1:0]  cumulative_count;
	logic [COUNT_W-1:0]  total_count;
	logic [SUM_W-1:0]    total_sum;
	logic                last;

	modport source (output valid, bucket_index, overflow_bucket, cumulative_count,
		total_count, total_sum, last, input ready);
	modport sink (input valid, bucket_index, overflow_bucket, cumulative_count,
		total_count, total_sum, last, output ready);
endinterface

### rtl/latency_bucket_histogram_core.sv
// Latency histogram core. An observe beat is compared against the bucket bounds one bound
// per cycle by a single 32-bit comparator, then the update state bumps the bucket count,
// the total count and the running sum (all saturating); the input is held after an observe
// is taken, through the bound search and the update state, until it is idle again. A snapshot
// streams NUM_BUCKETS result beats, one per cycle while the sink is ready, the running
// cumulative count built by one shared 48-bit saturating adder. Clear and unused kinds
// finish in the cycle they are taken. Bounds are written through cfg_we/cfg_index/cfg_data
// and are not checked for order: the lowest bucket whose bound covers the sample wins.
// depends on lbh_pkg, lbh_in_if, lbh_out_if, latency_bucket_histogram_core_assert.svh
module latency_bucket_histogram_core import lbh_pkg::*; #(
	parameter int NUM_BUCKETS = NUM_BUCKETS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	lbh_in_if.sink               req,
	lbh_out_if.source            rsp,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BOUND_W-1:0]   cfg_data
);

	localparam int IDX_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam logic [BUCKET_W-1:0] LAST_IDX   = BUCKET_W'(NUM_BUCKETS - 1);
	localparam logic [BUCKET_W-1:0] LAST_BOUND = BUCKET_W'(NUM_BUCKETS - 2);

	state_t               state_q, state_d;
	logic [BOUND_W-1:0]   bound_q [NUM_BOUNDS];
	logic [COUNT_W-1:0]   count_q [NUM_BUCKETS];
	logic [COUNT_W-1:0]   total_q;
	logic [SUM_W-1:0]     sum_q;
	logic [SAMPLE_W-1:0]  sample_q;
	logic [BUCKET_W-1:0]  idx_q;
	logic [BUCKET_W-1:0]  slot_q;
	logic [BUCKET_W-1:0]  k_q;
	logic [COUNT_W-1:0]   cum_q;
	logic                 out_valid_q;
	logic [BUCKET_W-1:0]  out_index_q;
	logic                 out_last_q;
	logic [COUNT_W-1:0]   out_cum_q;
	logic [COUNT_W-1:0]   out_total_q;
	logic [SUM_W-1:0]     out_sum_q;

	logic                 req_fire;
	logic                 hit;
	logic                 load_ok;
	logic [COUNT_W-1:0]   cnt_sel;
	logic [COUNT_W-1:0]   cnt_inc;
	logic [COUNT_W-1:0]   total_inc;
	logic [SUM_W:0]       sum_wide;
	logic [SUM_W-1:0]     sum_next;
	logic [COUNT_W:0]     cum_wide;
	logic [COUNT_W-1:0]   cum_next;

	assign req_fire = req.valid && req.ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_fire) begin
					case (req.kind)
						KIND_OBSERVE:  state_d = S_SEARCH;
						KIND_SNAPSHOT: state_d = S_SNAP;
						default:       state_d = S_IDLE;
					endcase
				end
			end
			S_SEARCH: begin
				if (hit || idx_q == LAST_BOUND)
					state_d = S_UPDATE;
			end
			S_UPDATE: state_d = S_IDLE;
			S_SNAP: begin
				if (load_ok && k_q == LAST_IDX)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// datapath and handshake outputs
	always_comb begin
		req.ready = (state_q == S_IDLE);
		load_ok   = (state_q == S_SNAP) && (!out_valid_q || rsp.ready);
		hit       = (sample_q <= bound_q[idx_q]);

		cnt_sel   = count_q[slot_q[IDX_W-1:0]];
		cnt_inc   = (&cnt_sel) ? cnt_sel : cnt_sel + COUNT_W'(1);
		total_inc = (&total_q) ? total_q : total_q + COUNT_W'(1);
		sum_wide  = {1'b0, sum_q} + {{(SUM_W - SAMPLE_W + 1){1'b0}}, sample_q};
		sum_next  = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];

		// shared saturating adder for the running cumulative count
		cum_wide  = {1'b0, cum_q} + {1'b0, count_q[k_q[IDX_W-1:0]]};
		cum_next  = cum_wide[COUNT_W] ? {COUNT_W{1'b1}} : cum_wide[COUNT_W-1:0];

		rsp.valid            = out_valid_q;
		rsp.bucket_index     = out_index_q;
		rsp.overflow_bucket  = out_last_q;
		rsp.cumulative_count = out_cum_q;
		rsp.total_count      = out_total_q;
		rsp.total_sum        = out_sum_q;
		rsp.last             = out_last_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			bound_q     <= BOUND_RESET;
			total_q     <= '0;
			sum_q       <= '0;
			for (int i = 0; i < NUM_BUCKETS; i++)
				count_q[i] <= '0;
		end else begin
			state_q <= state_d;

			if (load_ok)
				out_valid_q <= 1'b1;
			else if (rsp.ready)
				out_valid_q <= 1'b0;

			if (cfg_we && cfg_index < CFG_IDX_W'(NUM_BOUNDS))
				bound_q[cfg_index] <= cfg_data;

			if (req_fire && req.kind == KIND_CLEAR) begin
				total_q <= '0;
				sum_q   <= '0;
				for (int i = 0; i < NUM_BUCKETS; i++)
					count_q[i] <= '0;
			end else if (state_q == S_UPDATE) begin
				count_q[slot_q[IDX_W-1:0]] <= cnt_inc;
				total_q <= total_inc;
				sum_q   <= sum_next;
			end
		end
	end

	// sequencer working registers and result payload
	always_ff @(posedge clk) begin
		if (req_fire) begin
			sample_q <= req.sample;
			idx_q    <= '0;
			k_q      <= '0;
			cum_q    <= '0;
		end else if (state_q == S_SEARCH) begin
			if (hit)
				slot_q <= idx_q;
			else if (idx_q == LAST_BOUND)
				slot_q <= LAST_IDX;
			else
				idx_q <= idx_q + BUCKET_W'(1);
		end else if (load_ok) begin
			cum_q       <= cum_next;
			k_q         <= k_q + BUCKET_W'(1);
			out_index_q <= k_q;
			out_last_q  <= (k_q == LAST_IDX);
			out_cum_q   <= cum_next;
			out_total_q <= total_q;
			out_sum_q   <= sum_q;
		end
	end

`include "latency_bucket_histogram_core_assert.svh"

	`LBH_ASSERT_NOW(a_last_on_final, rsp.valid && rsp.last, rsp.bucket_index == LAST_IDX)
	`LBH_ASSERT_NEXT(a_snap_loads_beat, load_ok, rsp.valid)
	`LBH_ASSERT_NEXT(a_observe_searches, req_fire && req.kind == KIND_OBSERVE,
		state_q == S_SEARCH && !req.ready)

endmodule
